/* src/bm3_pkg.sv */
// Package for the 3x3 binary morphology block: register indexes, mode codes,
// the per-item control word and the window evaluation function.
// Depends on nothing; used by the top level, bm3_ctrl and bm3_window.
`default_nettype none

package bm3_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;
  localparam logic [1:0] CFG_THRESH = 2'd3;

  // Operating modes; the spare code behaves as a plain threshold.
  localparam logic [1:0] MODE_PASS   = 2'd0;
  localparam logic [1:0] MODE_ERODE  = 2'd1;
  localparam logic [1:0] MODE_DILATE = 2'd2;

  localparam int CFG_DW    = 13;
  localparam int IN_DW     = 24;
  localparam int OUT_DW    = 8;

  localparam logic [1:0] RST_MODE   = MODE_PASS;
  localparam logic [8:0] RST_THRESH = 9'd2;

  // Window bit index is column*3 + row, column 0 oldest, row 0 top.
  localparam logic [8:0] WIN_BLACK = 9'h1FF;
  localparam logic [8:0] PLUS_MASK = 9'h0BA;

  // Control word of one item as it moves from the counter stage to the window stage.
  typedef struct packed {
    logic valid;
    logic px;
    logic use_top;
    logic use_mid;
    logic col_start;
    logic pre_emit;
    logic pre_last;
    logic post_emit;
    logic post_last;
  } item_ctl_t;

  function automatic logic win_result(input logic [8:0] win, input logic [1:0] mode);
    logic res;
    case (mode)
      MODE_ERODE:  res = ((win & PLUS_MASK) == PLUS_MASK);
      MODE_DILATE: res = |win;
      default:     res = win[4];
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* src/binary_morphology_3x3_top.sv */
// Top level of the 3x3 binary morphology block (threshold, erosion, dilation).
// Depends on bm3_pkg, bm3_ctrl, bm3_window and bm3_outq.
//
// Usage:
// RGB pixels enter in raster order on the in_ stream; in_tuser selects a pixel
// item (0) or a flush item (1). Each result leaves on the out_ stream with
// out_tlast set on the final pixel of the frame. Results lag the input by one
// row plus one pixel; the last row plus one results of a frame are released
// by flush items (or further pixel items), one per item.
// Throughput is one item per clock cycle while in_tready is high: the line
// memory is read for the incoming column while the previous item writes back
// its own column. The item completing a result is registered in the counter
// stage, and the result is then registered in the queue that drives out_.
// The cfg_ port writes mode, width, height or threshold, as cfg_index selects;
// a size write restarts the frame. Configure only while the block is idle.
// Reset (rst_n low at a clock edge) restores the default configuration, zeroes
// the position counters, makes the window black and empties the result queue;
// the line memory needs no clearing, as no unwritten entry is ever used.
// When the receiver stalls, up to three results wait in a four-entry queue;
// in_tready falls once queued results plus the item in the window stage
// reach three.
`default_nettype none

module binary_morphology_3x3_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire                           clk,
  input  wire                           rst_n,
  // Configuration write port.
  input  wire                           cfg_we,
  input  wire [1:0]                     cfg_index,
  input  wire [bm3_pkg::CFG_DW-1:0]     cfg_data,
  // Input stream.
  input  wire                           in_tvalid,
  output logic                          in_tready,
  input  wire [bm3_pkg::IN_DW-1:0]      in_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  wire                           in_tuser,   // func
  // Result stream.
  output logic                          out_tvalid,
  input  wire                           out_tready,
  output logic [bm3_pkg::OUT_DW-1:0]    out_tdata,  // pixel_black[0], zeros above
  output logic                          out_tlast   // frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [1:0]         mode;
  logic               restart;
  logic               rd_en;
  logic [CW-1:0]      rd_addr;
  bm3_pkg::item_ctl_t s1_ctl;
  logic [CW-1:0]      s1_col;
  logic               res_valid, res_black, res_last;
  logic [2:0]         level;
  logic               out_black;

  assign in_tready = ((level + {2'b00, s1_ctl.valid}) <= 3'd2);

  bm3_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_func  (in_tuser),
    .in_red   (in_tdata[7:0]),
    .in_green (in_tdata[15:8]),
    .in_blue  (in_tdata[23:16]),
    .mode     (mode),
    .restart  (restart),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .s1_ctl   (s1_ctl),
    .s1_col   (s1_col)
  );

  bm3_window #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (restart),
    .mode     (mode),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .ctl      (s1_ctl),
    .col      (s1_col),
    .res_valid(res_valid),
    .res_black(res_black),
    .res_last (res_last)
  );

  bm3_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_black(res_black),
    .push_last (res_last),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_black (out_black),
    .out_last  (out_tlast),
    .level     (level)
  );

  assign out_tdata = {{(bm3_pkg::OUT_DW-1){1'b0}}, out_black};

endmodule

`default_nettype wire

/* src/bm3_ctrl.sv */
// Counter stage of the 3x3 morphology block: configuration registers, input
// and output position counters, and the control word for the window stage.
// Depends on bm3_pkg.
`default_nettype none

module bm3_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int HW = $clog2(MAX_HEIGHT),
  localparam int RW = $clog2(MAX_HEIGHT + 2)
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire [1:0]                    cfg_index,
  input  wire [bm3_pkg::CFG_DW-1:0]    cfg_data,
  input  wire                          in_valid,
  input  wire                          in_ready,
  input  wire                          in_func,
  input  wire [7:0]                    in_red,
  input  wire [7:0]                    in_green,
  input  wire [7:0]                    in_blue,
  output logic [1:0]                   mode,
  output logic                         restart,
  output logic                         rd_en,
  output logic [CW-1:0]                rd_addr,
  output bm3_pkg::item_ctl_t           s1_ctl,
  output logic [CW-1:0]                s1_col
);

  localparam int RST_W = (512 > MAX_WIDTH) ? MAX_WIDTH : 512;
  localparam int RST_H = (512 > MAX_HEIGHT) ? MAX_HEIGHT : 512;

  logic [1:0]    mode_r;
  logic [8:0]    thresh_r;
  logic [CW-1:0] wlast_r;
  logic [HW-1:0] hlast_r;

  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [HW-1:0] out_row_r, out_row_nxt;

  bm3_pkg::item_ctl_t ctl_r, ctl_nxt;
  logic [CW-1:0]      col_r;

  logic [31:0] w_val, h_val, w_clamp, h_clamp;
  logic        accept, pixel_phase, feed, thr_black, col_start, row_ge1, row_ge2;
  logic        out_is_last, emit, frame_done;

  assign restart = cfg_we && ((cfg_index == bm3_pkg::CFG_WIDTH) ||
                              (cfg_index == bm3_pkg::CFG_HEIGHT));

  // Sizes are stored already clamped, as the index of the last column and row.
  always_comb begin
    w_val = 32'(cfg_data[10:0]);
    h_val = 32'(cfg_data[12:0]);
    if (w_val < 32'd3) begin
      w_clamp = 32'd2;
    end else if (w_val > 32'(MAX_WIDTH)) begin
      w_clamp = 32'(MAX_WIDTH - 1);
    end else begin
      w_clamp = w_val - 32'd1;
    end
    if (h_val < 32'd3) begin
      h_clamp = 32'd2;
    end else if (h_val > 32'(MAX_HEIGHT)) begin
      h_clamp = 32'(MAX_HEIGHT - 1);
    end else begin
      h_clamp = h_val - 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= bm3_pkg::RST_MODE;
      thresh_r <= bm3_pkg::RST_THRESH;
      wlast_r  <= CW'(RST_W - 1);
      hlast_r  <= HW'(RST_H - 1);
    end else if (cfg_we) begin
      case (cfg_index)
        bm3_pkg::CFG_MODE:   mode_r   <= cfg_data[1:0];
        bm3_pkg::CFG_WIDTH:  wlast_r  <= w_clamp[CW-1:0];
        bm3_pkg::CFG_HEIGHT: hlast_r  <= h_clamp[HW-1:0];
        bm3_pkg::CFG_THRESH: thresh_r <= cfg_data[8:0];
        default:             mode_r   <= mode_r;
      endcase
    end
  end

  assign mode = mode_r;

  always_comb begin
    accept      = in_valid && in_ready;
    pixel_phase = (in_row_r <= RW'(hlast_r));
    // A flush item while pixels are still due is dropped.
    feed        = accept && !(pixel_phase && in_func);
    thr_black   = ({1'b0, in_red} < thresh_r) && ({1'b0, in_green} < thresh_r) &&
                  ({1'b0, in_blue} < thresh_r);
    col_start   = (in_col_r == '0);
    row_ge1     = (in_row_r != '0);
    row_ge2     = (in_row_r > RW'(1));
    out_is_last = (out_col_r == wlast_r) && (out_row_r == hlast_r);

    ctl_nxt           = '0;
    ctl_nxt.valid     = feed;
    ctl_nxt.px        = pixel_phase ? thr_black : 1'b1;
    ctl_nxt.use_top   = row_ge2;
    ctl_nxt.use_mid   = row_ge1;
    ctl_nxt.col_start = col_start;
    ctl_nxt.pre_emit  = feed && col_start && row_ge2;
    ctl_nxt.pre_last  = ctl_nxt.pre_emit && out_is_last;
    ctl_nxt.post_emit = feed && !col_start && row_ge1;
    ctl_nxt.post_last = ctl_nxt.post_emit && out_is_last;
    emit       = ctl_nxt.pre_emit || ctl_nxt.post_emit;
    frame_done = ctl_nxt.pre_last || ctl_nxt.post_last;

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (feed) begin
      if (in_col_r == wlast_r) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end
    if (emit) begin
      if (out_col_r == wlast_r) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + HW'(1);
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
    if (frame_done || restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      ctl_r     <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      ctl_r     <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (feed) begin
      col_r <= in_col_r;
    end
  end

  assign rd_en   = feed;
  assign rd_addr = in_col_r;
  assign s1_ctl  = ctl_r;
  assign s1_col  = col_r;

endmodule

`default_nettype wire

/* src/bm3_window.sv */
// Window stage of the 3x3 morphology block: the line memory holding the two
// rows above the input row, the 3x3 window register and the result logic.
// Depends on bm3_pkg.
`default_nettype none

module bm3_window #(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      restart,
  input  wire [1:0]                mode,
  input  wire                      rd_en,
  input  wire [CW-1:0]             rd_addr,
  input  wire bm3_pkg::item_ctl_t  ctl,
  input  wire [CW-1:0]             col,
  output logic                     res_valid,
  output logic                     res_black,
  output logic                     res_last
);

  // Each entry holds {row two above, row one above} for one column.
  logic [1:0] line_mem [MAX_WIDTH];
  logic [1:0] rd_data_r;

  logic [8:0] window_r, window_nxt;
  logic [8:0] win_pre, win_base, win_post;
  logic       top, mid, wr_en;
  logic [1:0] wr_data;

  // Reads run one column ahead of the write-back, and a column comes round
  // again only after a full row of at least three items, so no read ever
  // meets a pending write to the same entry.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= line_mem[rd_addr];
    end
    if (wr_en) begin
      line_mem[col] <= wr_data;
    end
  end

  always_comb begin
    top      = ctl.use_top ? rd_data_r[1] : 1'b1;
    mid      = ctl.use_mid ? rd_data_r[0] : 1'b1;
    win_pre  = {3'b111, window_r[8:3]};
    win_base = ctl.col_start ? bm3_pkg::WIN_BLACK : window_r;
    win_post = {ctl.px, mid, top, win_base[8:3]};

    wr_data   = {mid, ctl.px};
    wr_en     = ctl.valid && !ctl.pre_last;
    res_valid = ctl.valid && (ctl.pre_emit || ctl.post_emit);
    if (ctl.pre_emit) begin
      res_black = bm3_pkg::win_result(win_pre, mode);
      res_last  = ctl.pre_last;
    end else begin
      res_black = bm3_pkg::win_result(win_post, mode);
      res_last  = ctl.post_last;
    end

    if (ctl.pre_last || ctl.post_last) begin
      window_nxt = bm3_pkg::WIN_BLACK;
    end else begin
      window_nxt = win_post;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      window_r <= bm3_pkg::WIN_BLACK;
    end else if (ctl.valid) begin
      window_r <= window_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/bm3_outq.sv */
// Four-entry result queue of the 3x3 morphology block; it decouples the
// window stage from a stalling receiver.
// Depends on no other module.
`default_nettype none

module bm3_outq (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        push,
  input  wire        push_black,
  input  wire        push_last,
  output logic       out_valid,
  input  wire        out_ready,
  output logic       out_black,
  output logic       out_last,
  output logic [2:0] level
);

  logic [1:0] entry_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r;
  logic       pop;

  assign out_valid = (count_r != 3'd0);
  assign pop       = out_valid && out_ready;
  assign out_black = entry_r[rd_ptr_r][0];
  assign out_last  = entry_r[rd_ptr_r][1];
  assign level     = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= {push_last, push_black};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 2'd1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      if (push && !pop) begin
        count_r <= count_r + 3'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking bench for binary_morphology_3x3_top: a short frame table, then
// random frames of many sizes, modes and thresholds, checked against an
// in-bench bit-level model. Needs bm3_pkg and the block's sources only.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_W       = 1024;
  localparam int MAX_H       = 4096;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_WAIT  = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_GOAL = 1000;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  localparam logic [8:0] ALL_BLACK  = 9'h1FF;
  localparam logic [8:0] PLUS_SHAPE = 9'b010_111_010;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_WHITE, CHK_BLACK} chk_t;
  typedef enum logic {ROW_CFG, ROW_ITEM} row_t;

  typedef struct packed {
    row_t        kind;
    logic [1:0]  reg_idx;
    logic [12:0] value;
    logic        func;
    logic [23:0] colour;  // {blue, green, red}
    chk_t        chk;
    logic        last;
  } step_t;

  typedef struct packed {
    logic black;
    logic last;
  } due_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [1:0]                 cfg_index;
  logic [bm3_pkg::CFG_DW-1:0] cfg_data;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [bm3_pkg::IN_DW-1:0]  in_tdata;   // red[7:0], green[15:8], blue[23:16]
  logic                       in_tuser;   // func
  logic                       out_tvalid;
  logic                       out_tready;
  logic [bm3_pkg::OUT_DW-1:0] out_tdata;  // pixel_black[0], zeros above
  logic                       out_tlast;  // frame_last

  binary_morphology_3x3_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Model state: configuration, line stores, 3x3 window and frame counters.
  logic [1:0]  cfg_mode_q;
  logic [10:0] cfg_w_q;
  logic [12:0] cfg_h_q;
  logic [8:0]  cfg_thr_q;
  bit          row_above2 [MAX_W];
  bit          row_above1 [MAX_W];
  logic [8:0]  shade;
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned done_count;

  due_t due_pixels [$];
  int   err_count   = 0;
  int   live_items  = 0;
  int   quiet_count = 0;
  bit   dirty       = 1'b0;
  bit   calm        = 1'b0;
  bit   hold_off    = 1'b0;

  step_t dir_steps [34] = '{
    '{ROW_CFG,  bm3_pkg::CFG_WIDTH,  13'd3,   FUNC_PIXEL, 24'h000000, CHK_NONE,  1'b0},
    '{ROW_CFG,  bm3_pkg::CFG_HEIGHT, 13'd3,   FUNC_PIXEL, 24'h000000, CHK_NONE,  1'b0},
    // Flush while pixels are still due is dropped.
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_FLUSH, 24'h000000, CHK_NONE,  1'b0},
    // Reset threshold of 2: channel values 0 and 1 count, 2 does not.
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'h000000, CHK_NONE,  1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'h010101, CHK_NONE,  1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'h010102, CHK_NONE,  1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'h010201, CHK_NONE,  1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'h020101, CHK_BLACK, 1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'hFFFFFF, CHK_BLACK, 1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'h000000, CHK_WHITE, 1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'hFF0000, CHK_WHITE, 1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'h0000FF, CHK_WHITE, 1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_FLUSH, 24'h000000, CHK_WHITE, 1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_FLUSH, 24'h000000, CHK_BLACK, 1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_FLUSH, 24'h000000, CHK_WHITE, 1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_FLUSH, 24'h000000, CHK_WHITE, 1'b1},
    // The frame has ended, so this flush belongs to the next one and is dropped.
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_FLUSH, 24'h000000, CHK_NONE,  1'b0},
    // Sizes below the minimum clamp to 3; a threshold above 255 makes all black.
    '{ROW_CFG,  bm3_pkg::CFG_MODE,   13'(bm3_pkg::MODE_ERODE), FUNC_PIXEL, 24'h000000,
      CHK_NONE, 1'b0},
    '{ROW_CFG,  bm3_pkg::CFG_WIDTH,  13'd0,   FUNC_PIXEL, 24'h000000, CHK_NONE,  1'b0},
    '{ROW_CFG,  bm3_pkg::CFG_HEIGHT, 13'd2,   FUNC_PIXEL, 24'h000000, CHK_NONE,  1'b0},
    '{ROW_CFG,  bm3_pkg::CFG_THRESH, 13'd256, FUNC_PIXEL, 24'h000000, CHK_NONE,  1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'hFFFFFF, CHK_NONE,  1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'hFFFFFF, CHK_NONE,  1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'hFFFFFF, CHK_NONE,  1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'hFFFFFF, CHK_NONE,  1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'hFFFFFF, CHK_BLACK, 1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'hFFFFFF, CHK_BLACK, 1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'hFFFFFF, CHK_BLACK, 1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'hFFFFFF, CHK_BLACK, 1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'hFFFFFF, CHK_BLACK, 1'b0},
    // Pixels after the frame stand in for flushes.
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'h000000, CHK_BLACK, 1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_FLUSH, 24'h000000, CHK_BLACK, 1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_PIXEL, 24'h123456, CHK_BLACK, 1'b0},
    '{ROW_ITEM, bm3_pkg::CFG_MODE,   13'd0,   FUNC_FLUSH, 24'h000000, CHK_BLACK, 1'b1}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned span_w();
    return (cfg_w_q < 3) ? 3 : (cfg_w_q > MAX_W) ? MAX_W : int'(cfg_w_q);
  endfunction

  function automatic int unsigned span_h();
    return (cfg_h_q < 3) ? 3 : (cfg_h_q > MAX_H) ? MAX_H : int'(cfg_h_q);
  endfunction

  function automatic void frame_restart();
    shade      = ALL_BLACK;
    col_pos    = 0;
    row_pos    = 0;
    done_count = 0;
  endfunction

  // Evaluates the window for the current centre and advances the frame count.
  function automatic void emit_pixel(output due_t res);
    res.last = (done_count + 1 >= span_w() * span_h());
    case (cfg_mode_q)
      bm3_pkg::MODE_ERODE:  res.black = ((shade & PLUS_SHAPE) == PLUS_SHAPE);
      bm3_pkg::MODE_DILATE: res.black = |shade;
      default:              res.black = shade[4];
    endcase
    done_count++;
    if (res.last) frame_restart();
  endfunction

  // Advances the model by one accepted item; live is low for a dropped flush.
  function automatic void morph_step(input logic func, input logic [23:0] colour,
                                     output bit live, output bit got, output due_t res);
    int unsigned w, h, c;
    bit px, top, mid;
    w    = span_w();
    h    = span_h();
    live = 1'b1;
    got  = 1'b0;
    res  = '0;
    if (row_pos < h) begin
      if (func == FUNC_FLUSH) begin
        live = 1'b0;
        return;
      end
      px = (colour[7:0] < cfg_thr_q) && (colour[15:8] < cfg_thr_q) &&
           (colour[23:16] < cfg_thr_q);
    end else begin
      // Rows below the frame read as black.
      px = 1'b1;
    end
    c = (col_pos >= w) ? 0 : col_pos;
    if (c == 0) begin
      // The last centre of the previous row is finished with a black column.
      if (row_pos >= 2) begin
        shade = (shade >> 3) | 9'h1C0;
        got   = 1'b1;
        emit_pixel(res);
        if (res.last) return;
      end
      shade = ALL_BLACK;
    end
    top = (row_pos >= 2) ? row_above2[c] : 1'b1;
    mid = (row_pos >= 1) ? row_above1[c] : 1'b1;
    row_above2[c] = mid;
    row_above1[c] = px;
    shade = (shade >> 3) | {px, mid, top, 6'b0};
    if (c >= 1 && row_pos >= 1) begin
      got = 1'b1;
      emit_pixel(res);
      if (res.last) return;
    end
    c++;
    if (c >= w) begin
      c = 0;
      row_pos++;
    end
    col_pos = c;
  endfunction

  function automatic logic [8:0] pick_thresh();
    case ($urandom_range(9))
      0:       return 9'd0;
      1:       return 9'($urandom_range(511, 256));
      default: return 9'($urandom_range(255, 1));
    endcase
  endfunction

  // Random colour, black with the given chance in percent where the threshold allows.
  function automatic logic [23:0] pick_colour(int density);
    logic [7:0] ch [3];
    int lim;
    for (int i = 0; i < 3; i++) ch[i] = 8'($urandom_range(255));
    if ($urandom_range(99) < density) begin
      if (cfg_thr_q > 0) begin
        lim = (cfg_thr_q > 256) ? 255 : int'(cfg_thr_q) - 1;
        for (int i = 0; i < 3; i++) ch[i] = 8'($urandom_range(lim, 0));
      end
    end else if (cfg_thr_q <= 255) begin
      ch[$urandom_range(2)] = 8'($urandom_range(255, int'(cfg_thr_q)));
    end
    return {ch[2], ch[1], ch[0]};
  endfunction

  task automatic flag_error(input string what);
    $display("ERROR at %0t: %s", $time, what);
    err_count++;
  endtask

  // Called just after a falling edge; returns just after a falling edge, once the write has been taken.
  task automatic cfg_write(input logic [1:0] idx, input logic [12:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      bm3_pkg::CFG_MODE:   cfg_mode_q = value[1:0];
      bm3_pkg::CFG_WIDTH:  begin
        cfg_w_q = value[10:0];
        frame_restart();
      end
      bm3_pkg::CFG_HEIGHT: begin
        cfg_h_q = value;
        frame_restart();
      end
      bm3_pkg::CFG_THRESH: cfg_thr_q = value[8:0];
      default:             ;
    endcase
    @(negedge clk);
  endtask

  // Offers one item, waits for the handshake and files what it should produce.
  task automatic send_item(input logic func, input logic [23:0] colour,
                           input chk_t chk, input logic last);
    bit live, got;
    due_t res;
    while (!calm && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= colour;
    do @(posedge clk); while (!in_tready);
    morph_step(func, colour, live, got, res);
    case (chk)
      CHK_MODEL: if (got) due_pixels.push_back(res);
      CHK_WHITE: due_pixels.push_back(due_t'{black: 1'b0, last: last});
      CHK_BLACK: due_pixels.push_back(due_t'{black: 1'b1, last: last});
      default:   ;
    endcase
    if (live) live_items++;
    dirty = 1'b1;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (due_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    dirty = 1'b0;
  endtask

  // Result side: random back-pressure, or one long hold when asked for.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
        out_tready <= 1'b1;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  always @(posedge clk) begin : check_results
    due_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_pixels.size() == 0) begin
        flag_error("result arrived with nothing pending");
      end else begin
        want = due_pixels.pop_front();
        if (out_tdata !== {{(bm3_pkg::OUT_DW - 1){1'b0}}, want.black})
          flag_error($sformatf("pixel data %h, expected black=%0b", out_tdata, want.black));
        if (out_tlast !== want.last)
          flag_error($sformatf("frame_last %b, expected %0b", out_tlast, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= QUIET_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    int phase, k, npix, ew, eh, density, tweak_at;
    bit abandon;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = FUNC_PIXEL;
    out_tready = 1'b0;
    cfg_mode_q = bm3_pkg::MODE_PASS;
    cfg_w_q    = 11'd512;
    cfg_h_q    = 13'd512;
    cfg_thr_q  = 9'd2;
    frame_restart();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == ROW_CFG) begin
        if (dirty) wait_idle();
        cfg_write(dir_steps[i].reg_idx, dir_steps[i].value);
      end else begin
        cfg_we <= 1'b0;
        send_item(dir_steps[i].func, dir_steps[i].colour, dir_steps[i].chk,
                  dir_steps[i].last);
      end
    end

    // Random small frames until the item budget is used up.
    phase = 0;
    while (live_items < RANDOM_GOAL) begin
      if (dirty) wait_idle();
      if ($urandom_range(3) == 0) begin
        cfg_write(bm3_pkg::CFG_WIDTH, 13'($urandom_range(2047)));
        cfg_write(bm3_pkg::CFG_HEIGHT, 13'($urandom_range(8191)));
      end
      cfg_write(bm3_pkg::CFG_MODE, (phase < 4) ? 13'(phase) : 13'($urandom_range(3)));
      cfg_write(bm3_pkg::CFG_THRESH, 13'(pick_thresh()));
      cfg_write(bm3_pkg::CFG_WIDTH, ($urandom_range(9) == 0) ? 13'($urandom_range(2))
                                                             : 13'($urandom_range(12, 3)));
      cfg_write(bm3_pkg::CFG_HEIGHT, ($urandom_range(9) == 0) ? 13'($urandom_range(2))
                                                              : 13'($urandom_range(8, 3)));
      cfg_we <= 1'b0;
      calm = (phase >= 6 && phase < 10);
      // The result side stalls long enough for the input to back up.
      if (phase == 1) hold_off = 1'b1;

      ew       = span_w();
      eh       = span_h();
      npix     = ew * eh;
      density  = $urandom_range(80, 20);
      abandon  = (phase > 3 && $urandom_range(9) == 0);
      if (abandon) npix = $urandom_range(npix - 1, 1);
      tweak_at = (npix > 1 && $urandom_range(4) == 0) ? $urandom_range(npix - 1, 1) : 0;

      for (k = 0; k < npix; k++) begin
        // Mode and threshold change part way through the frame, once idle.
        if (k == tweak_at && k > 0) begin
          wait_idle();
          cfg_write(bm3_pkg::CFG_MODE, 13'($urandom_range(3)));
          cfg_write(bm3_pkg::CFG_THRESH, 13'(pick_thresh()));
          cfg_we <= 1'b0;
        end
        if ($urandom_range(99) < 6)
          send_item(FUNC_FLUSH, 24'($urandom_range(24'hFFFFFF)), CHK_MODEL, 1'b0);
        send_item(FUNC_PIXEL, pick_colour(density), CHK_MODEL, 1'b0);
      end
      if (!abandon) begin
        for (k = 0; k < ew + 1; k++)
          send_item(($urandom_range(3) != 0) ? FUNC_FLUSH : FUNC_PIXEL,
                    24'($urandom_range(24'hFFFFFF)), CHK_MODEL, 1'b0);
        if ($urandom_range(3) == 0)
          send_item(FUNC_FLUSH, 24'($urandom_range(24'hFFFFFF)), CHK_MODEL, 1'b0);
      end
      phase++;
    end

    calm = 1'b0;
    wait_idle();
    if (err_count == 0 && due_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
